>>> rtl/core/sqmm_pkg.sv
// Shared constants and item types for the square matrix multiplier.
`default_nettype none
package sqmm_pkg;

	localparam int MAX_SIZE    = 8;
	localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int IDX_W       = 3;
	localparam int SIZE_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

	typedef struct packed {
		logic signed [DATA_W-1:0] a_value;
		logic signed [DATA_W-1:0] b_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product_value;
		logic [IDX_W-1:0]         out_row;
		logic [IDX_W-1:0]         out_col;
		logic                     last_result;
	} out_item_t;

	// Control that travels alongside one operand pair through the MAC.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/sqmm_store.sv
// Operand memories holding the left and right matrices.
`default_nettype none
module sqmm_store (
	input  wire logic                             clk,
	input  wire logic                             wr_en,
	input  wire logic [sqmm_pkg::ADDR_W-1:0]      wr_addr,
	input  wire logic [sqmm_pkg::DATA_W-1:0]      wr_a,
	input  wire logic [sqmm_pkg::DATA_W-1:0]      wr_b,
	input  wire logic                             rd_en,
	input  wire logic [sqmm_pkg::ADDR_W-1:0]      rd_a_addr,
	input  wire logic [sqmm_pkg::ADDR_W-1:0]      rd_b_addr,
	output logic      [sqmm_pkg::DATA_W-1:0]      rd_a_q,
	output logic      [sqmm_pkg::DATA_W-1:0]      rd_b_q
);

	logic [sqmm_pkg::DATA_W-1:0] left_mem  [sqmm_pkg::STORE_DEPTH];
	logic [sqmm_pkg::DATA_W-1:0] right_mem [sqmm_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			left_mem[wr_addr]  <= wr_a;
			right_mem[wr_addr] <= wr_b;
		end
		if (rd_en) begin
			rd_a_q <= left_mem[rd_a_addr];
			rd_b_q <= right_mem[rd_b_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/sqmm_mac.sv
// Shared multiply-accumulate unit with a registered product stage.
`default_nettype none
module sqmm_mac (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sqmm_pkg::mac_ctrl_t         ctrl,
	input  wire logic [sqmm_pkg::DATA_W-1:0] op_a,
	input  wire logic [sqmm_pkg::DATA_W-1:0] op_b,
	output logic      [sqmm_pkg::DATA_W-1:0] acc_q,
	output logic                             done_q
);

	sqmm_pkg::mac_ctrl_t             ctrl_s1;
	sqmm_pkg::mac_ctrl_t             ctrl_s2;
	logic [sqmm_pkg::DATA_W-1:0]     prod_lo;
	logic [sqmm_pkg::DATA_W-1:0]     prod_s2;

	// Only the low half of the product matters as sums wrap at the data width.
	assign prod_lo = op_a * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			done_q  <= 1'b0;
		end else begin
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
			done_q  <= ctrl_s2.valid & ctrl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_lo;
		if (ctrl_s2.valid) begin
			acc_q <= ctrl_s2.first ? prod_s2 : acc_q + prod_s2;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/square_matrix_multiply_core.sv
// Top level of the square matrix multiplier: load sequencer, compute sequencer and result register.
`default_nettype none
// The block multiplies two square n-by-n matrices of 32-bit two's complement integers, where n
// is the matrix_size register (reset value 8; 0 behaves as 1 and anything above 8 as 8). Each
// input item carries one element of A and the matching element of B in row-major order, and is
// taken while the block is idle. The item that completes the n*n-th pair starts the
// computation, during which in_ready is low. Every element C[row][col] is formed by one shared
// 32x32 multiply-accumulate unit fed from two 64-entry operand memories, one multiply per cycle
// while the element is accumulating. An element first issues its n operand pairs; its last
// product then passes the memory read, the product register and the accumulator, and the
// element waits in the result register until out_ready takes it. The item that completes a
// load therefore keeps in_ready low until the final element of C has been taken. The elements
// leave in row-major order with their coordinates, the final one carrying last_result; after it
// is taken the block is idle again and loads the next pair of matrices. Sums wrap modulo 2^32.
// The size should only be written while the block is idle.
module square_matrix_multiply_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [sqmm_pkg::SIZE_W-1:0]    cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire sqmm_pkg::in_item_t             in_item,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output sqmm_pkg::out_item_t                 out_item
);

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CALC  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t                              state_q;
	logic [sqmm_pkg::SIZE_W-1:0]         size_q;
	logic [sqmm_pkg::SIZE_W-1:0]         size_eff;
	logic [sqmm_pkg::CNT_W-1:0]          load_q;
	logic [sqmm_pkg::CNT_W-1:0]          load_next;
	logic [2*sqmm_pkg::SIZE_W-1:0]       total;
	logic                                in_take;
	logic                                out_take;

	logic [sqmm_pkg::SIZE_W-1:0]         n_q;
	logic [sqmm_pkg::IDX_W-1:0]          nm1;
	logic [sqmm_pkg::IDX_W-1:0]          row_q;
	logic [sqmm_pkg::IDX_W-1:0]          col_q;
	logic [sqmm_pkg::IDX_W-1:0]          k_q;
	logic [sqmm_pkg::ADDR_W-1:0]         row_base_q;
	logic [sqmm_pkg::ADDR_W-1:0]         row_base_next;
	logic [sqmm_pkg::ADDR_W-1:0]         a_addr_q;
	logic [sqmm_pkg::ADDR_W-1:0]         b_addr_q;
	logic                                k_last;
	logic                                col_last;
	logic                                row_last;

	sqmm_pkg::mac_ctrl_t                 mac_ctrl;
	logic [sqmm_pkg::DATA_W-1:0]         rd_a;
	logic [sqmm_pkg::DATA_W-1:0]         rd_b;
	logic [sqmm_pkg::DATA_W-1:0]         acc;
	logic                                mac_done;

	logic                                out_valid_q;
	sqmm_pkg::out_item_t                 out_item_q;

	// Clamp the programmed size into the range the memories can hold.
	always_comb begin
		if (size_q == '0) begin
			size_eff = sqmm_pkg::SIZE_W'(1);
		end else if (size_q > sqmm_pkg::SIZE_W'(sqmm_pkg::MAX_SIZE)) begin
			size_eff = sqmm_pkg::SIZE_W'(sqmm_pkg::MAX_SIZE);
		end else begin
			size_eff = size_q;
		end
	end

	assign total     = (2*sqmm_pkg::SIZE_W)'(size_eff) * (2*sqmm_pkg::SIZE_W)'(size_eff);
	assign load_next = load_q + sqmm_pkg::CNT_W'(1);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign out_take  = out_valid_q & out_ready;

	assign nm1           = sqmm_pkg::IDX_W'(n_q - sqmm_pkg::SIZE_W'(1));
	assign k_last        = (k_q == nm1);
	assign col_last      = (col_q == nm1);
	assign row_last      = (row_q == nm1);
	assign row_base_next = row_base_q + sqmm_pkg::ADDR_W'(n_q);

	// One operand pair is issued to the memories and the MAC each cycle of accumulation.
	always_comb begin
		mac_ctrl.valid = (state_q == ST_CALC);
		mac_ctrl.first = (k_q == '0);
		mac_ctrl.last  = k_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= sqmm_pkg::SIZE_RESET;
		end else if (cfg_write) begin
			size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			load_q      <= '0;
			out_valid_q <= 1'b0;
			n_q         <= sqmm_pkg::SIZE_RESET;
			row_q       <= '0;
			col_q       <= '0;
			k_q         <= '0;
			row_base_q  <= '0;
			a_addr_q    <= '0;
			b_addr_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						// A shrunken size can leave the count at or past the new total.
						if ({1'b0, load_next} >= total) begin
							load_q     <= '0;
							n_q        <= size_eff;
							row_q      <= '0;
							col_q      <= '0;
							k_q        <= '0;
							row_base_q <= '0;
							a_addr_q   <= '0;
							b_addr_q   <= '0;
							state_q    <= ST_CALC;
						end else begin
							load_q <= load_next;
						end
					end
				end
				ST_CALC: begin
					if (k_last) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q      <= k_q + sqmm_pkg::IDX_W'(1);
						a_addr_q <= a_addr_q + sqmm_pkg::ADDR_W'(1);
						b_addr_q <= b_addr_q + sqmm_pkg::ADDR_W'(n_q);
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_take) begin
						out_valid_q <= 1'b0;
						k_q         <= '0;
						if (row_last && col_last) begin
							state_q <= ST_IDLE;
						end else if (col_last) begin
							col_q      <= '0;
							row_q      <= row_q + sqmm_pkg::IDX_W'(1);
							row_base_q <= row_base_next;
							a_addr_q   <= row_base_next;
							b_addr_q   <= '0;
							state_q    <= ST_CALC;
						end else begin
							col_q    <= col_q + sqmm_pkg::IDX_W'(1);
							a_addr_q <= row_base_q;
							b_addr_q <= sqmm_pkg::ADDR_W'(col_q) + sqmm_pkg::ADDR_W'(1);
							state_q  <= ST_CALC;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The result register is loaded when the final product of an element has been summed.
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN && mac_done) begin
			out_item_q.product_value <= acc;
			out_item_q.out_row       <= row_q;
			out_item_q.out_col       <= col_q;
			out_item_q.last_result   <= row_last & col_last;
		end
	end

	sqmm_store u_store (
		.clk       (clk),
		.wr_en     (in_take),
		.wr_addr   (load_q[sqmm_pkg::ADDR_W-1:0]),
		.wr_a      (in_item.a_value),
		.wr_b      (in_item.b_value),
		.rd_en     (mac_ctrl.valid),
		.rd_a_addr (a_addr_q),
		.rd_b_addr (b_addr_q),
		.rd_a_q    (rd_a),
		.rd_b_q    (rd_b)
	);

	sqmm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.op_a   (rd_a),
		.op_b   (rd_b),
		.acc_q  (acc),
		.done_q (mac_done)
	);

endmodule
`default_nettype wire

>>> sim/square_matrix_multiply_core_test.sv
// Self-checking testbench for square_matrix_multiply_core with an in-line product predictor.
`default_nettype none
module square_matrix_multiply_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Number of input items offered before the run winds down.
	localparam int ITEM_TARGET    = 410;
	// Cycles of silence on both channels before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;
	// Length of the one deliberate receiver hold-off, in clock cycles.
	localparam int LONG_HOLD      = 300;
	// Cycles left after every owed element has arrived before the size register is touched.
	localparam int CFG_SETTLE     = 16;
	// Cycles watched after the last expected result, to catch stray output.
	localparam int DRAIN_CYCLES   = 2 * sqmm_pkg::MAX_SIZE + 8;

	localparam logic [sqmm_pkg::DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
	localparam logic [sqmm_pkg::DATA_W-1:0] WORD_MAX  = 32'h7fff_ffff;
	localparam logic [sqmm_pkg::DATA_W-1:0] WORD_ONES = 32'hffff_ffff;
	localparam logic [sqmm_pkg::DATA_W-1:0] WORD_ZERO = 32'h0000_0000;

	// Receiver stall patterns.
	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_TOGGLE
	} rx_mode_t;

	// Tracks what the block holds and the product elements it still owes.
	class product_ledger;
		logic [sqmm_pkg::SIZE_W-1:0]  size_reg;
		logic [sqmm_pkg::DATA_W-1:0]  left_mem [sqmm_pkg::STORE_DEPTH];
		logic [sqmm_pkg::DATA_W-1:0]  right_mem [sqmm_pkg::STORE_DEPTH];
		logic [sqmm_pkg::CNT_W-1:0]   loaded;
		sqmm_pkg::out_item_t          owed [$];
		int                           errors;

		function new();
			size_reg = sqmm_pkg::SIZE_RESET;
			loaded   = '0;
			errors   = 0;
			foreach (left_mem[i]) begin
				left_mem[i]  = '0;
				right_mem[i] = '0;
			end
		endfunction

		// Side length in force: zero behaves as one, anything above the maximum as the maximum.
		function int side();
			int n;
			n = int'(size_reg);
			if (n < 1)
				n = 1;
			if (n > sqmm_pkg::MAX_SIZE)
				n = sqmm_pkg::MAX_SIZE;
			return n;
		endfunction

		function void resize(logic [sqmm_pkg::SIZE_W-1:0] value);
			size_reg = value;
		endfunction

		function int outstanding();
			return owed.size();
		endfunction

		// Store one operand pair; on the pair that completes a load, work out every element of C.
		function void absorb_pair(sqmm_pkg::in_item_t item);
			int n;
			int total;
			int r;
			int c;
			int k;
			logic [sqmm_pkg::DATA_W-1:0] acc;
			sqmm_pkg::out_item_t elem;
			n = side();
			total = n * n;
			if (int'(loaded) < sqmm_pkg::STORE_DEPTH) begin
				left_mem[loaded]  = item.a_value;
				right_mem[loaded] = item.b_value;
			end
			loaded = loaded + 1'b1;
			if (int'(loaded) < total)
				return;
			for (r = 0; r < n; r++) begin
				for (c = 0; c < n; c++) begin
					acc = '0;
					for (k = 0; k < n; k++)
						acc = acc + left_mem[(r * n + k) % sqmm_pkg::STORE_DEPTH]
							* right_mem[(k * n + c) % sqmm_pkg::STORE_DEPTH];
					elem.product_value = acc;
					elem.out_row       = sqmm_pkg::IDX_W'(r);
					elem.out_col       = sqmm_pkg::IDX_W'(c);
					elem.last_result   = (r == n - 1) && (c == n - 1);
					owed.push_back(elem);
				end
			end
			loaded = '0;
		endfunction

		// Compare one accepted result with the oldest element still owed.
		function void match_product(sqmm_pkg::out_item_t got);
			sqmm_pkg::out_item_t want;
			if (owed.size() == 0) begin
				$error("product item with nothing owed: value %0d row %0d col %0d last %0d",
					got.product_value, got.out_row, got.out_col, got.last_result);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.product_value !== want.product_value) begin
				$error("product_value: expected %0d, actual %0d",
					want.product_value, got.product_value);
				errors++;
			end
			if (got.out_row !== want.out_row) begin
				$error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
				errors++;
			end
			if (got.out_col !== want.out_col) begin
				$error("out_col: expected %0d, actual %0d", want.out_col, got.out_col);
				errors++;
			end
			if (got.last_result !== want.last_result) begin
				$error("last_result: expected %0d, actual %0d",
					want.last_result, got.last_result);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_write;
	logic [sqmm_pkg::SIZE_W-1:0] cfg_data;
	logic                        in_valid;
	logic                        in_ready;
	sqmm_pkg::in_item_t          in_item;
	logic                        out_valid;
	logic                        out_ready;
	sqmm_pkg::out_item_t         out_item;

	product_ledger ledger = new();

	// Shared between the stimulus and the receiver: a request for the long hold-off.
	bit long_hold_req = 1'b0;
	// Items accepted so far, and the remaining length of the sender's current burst.
	int pairs_sent    = 0;
	int burst_left    = 0;
	int silent_cycles = 0;

	square_matrix_multiply_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Operand values lean towards the corners of the 32-bit range, where wrapping bites.
	function automatic logic [sqmm_pkg::DATA_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return WORD_ONES;
			3: return WORD_ZERO;
			4: return sqmm_pkg::DATA_W'($urandom_range(0, 15));
			5: return ~sqmm_pkg::DATA_W'($urandom_range(0, 15));
			default: return $urandom();
		endcase
	endfunction

	// Offer one item and hold it, unchanged, until the block takes it. Consecutive items with
	// no gap between them keep in_valid high, so valid is never dropped and raised in one step.
	task automatic offer_pair(logic [sqmm_pkg::DATA_W-1:0] a, logic [sqmm_pkg::DATA_W-1:0] b);
		sqmm_pkg::in_item_t item;
		item.a_value = a;
		item.b_value = b;
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ledger.absorb_pair(item);
		pairs_sent++;
	endtask

	// Leave the input channel empty for a number of cycles.
	task automatic idle_for(int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	// Decide, after each item, whether the current burst goes on or a gap opens.
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle_for($urandom_range(1, 10));
			// Now and again a long run with no gaps at all.
			burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(0, 24);
		end
	endtask

	// Stop sending, let every owed element drain, give the block time to settle after the
	// last item, and only then write the size register.
	task automatic resize(logic [sqmm_pkg::SIZE_W-1:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.outstanding() != 0)
			@(posedge clk);
		repeat (CFG_SETTLE)
			@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		ledger.resize(value);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Every accepted result is checked against the oldest owed element.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.match_product(out_item);
	end

	// The watchdog counts cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				silent_cycles <= 0;
			else
				silent_cycles <= silent_cycles + 1;
			if (silent_cycles >= WATCHDOG_LIMIT) begin
				$display("square_matrix_multiply_core verification failed");
				$finish;
			end
		end
	end

	// The receiver stalls on its own pattern, which is drawn anew at random for each span. When the
	// stimulus asks for it, it holds off for a long stretch so that the block fills up and
	// drops in_ready while the sender keeps offering items.
	initial begin
		rx_mode_t mode;
		int       span;
		int       hold_left;
		bit       toggle;
		hold_left = 0;
		toggle    = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 80);
			repeat (span) begin
				@(negedge clk);
				if (long_hold_req) begin
					long_hold_req = 1'b0;
					hold_left     = LONG_HOLD;
				end
				if (hold_left > 0) begin
					hold_left--;
					out_ready <= 1'b0;
				end else begin
					case (mode)
						RX_ALWAYS: out_ready <= 1'b1;
						RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
						RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
						default: begin
							toggle = ~toggle;
							out_ready <= toggle;
						end
					endcase
				end
			end
		end
	end

	// Main stimulus: reset, a short directed part, then random matrices of varied size.
	initial begin
		int  code;
		int  n;
		int  total;
		int  sets;
		int  count;
		int  phase;
		bit  broken;
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_item   = '0;
		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;

		// At the reset size of eight, load a handful of corner values. Shrinking the size to
		// two below the count already loaded means the very next item completes the load,
		// and the product is taken from the first four pairs.
		offer_pair(WORD_MIN, WORD_MAX);
		offer_pair(WORD_MAX, WORD_MIN);
		offer_pair(WORD_ONES, WORD_ONES);
		offer_pair(WORD_ZERO, WORD_MIN);
		offer_pair(WORD_MAX, WORD_MAX);
		resize(4'd2);
		offer_pair(32'd1, WORD_ONES);

		// A size of zero behaves as one: every item is a complete one-by-one product.
		resize(4'd0);
		offer_pair(WORD_MIN, WORD_MIN);
		offer_pair(WORD_MAX, WORD_MAX);
		offer_pair(WORD_ONES, WORD_MIN);
		resize(4'd1);
		offer_pair(WORD_MAX, WORD_ONES);

		// A full two-by-two product of extremes, then a load that grows from two to three
		// part of the way through and finishes as a three-by-three product.
		resize(4'd2);
		offer_pair(WORD_MAX, WORD_MIN);
		offer_pair(WORD_MIN, WORD_ONES);
		offer_pair(WORD_ONES, WORD_MAX);
		offer_pair(WORD_ZERO, 32'd1);
		offer_pair(32'd123, 32'hffff_fe38);
		offer_pair(pick_word(), pick_word());
		resize(4'd3);
		repeat (7) begin
			offer_pair(pick_word(), pick_word());
			pace();
		end

		// Random part. Each phase picks a size, mostly small, with the occasional eight and
		// the occasional value that is clamped, and loads whole matrices. A few phases break
		// off part of the way through a load and change the size under it. The first phase is
		// several three-by-three products during which the receiver holds off for a long time.
		phase = 0;
		while (pairs_sent < ITEM_TARGET) begin
			if (phase == 0) begin
				code = 3;
			end else begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: code = $urandom_range(1, 4);
					12, 13, 14: code = $urandom_range(5, 7);
					15: code = 0;
					16: code = 8;
					17: code = $urandom_range(9, 15);
					default: code = $urandom_range(2, 3);
				endcase
			end
			resize(sqmm_pkg::SIZE_W'(code));
			n     = ledger.side();
			total = n * n;
			if (phase == 0) begin
				sets = 4;
				long_hold_req = 1'b1;
			end else begin
				sets = (n >= 6) ? 1 : $urandom_range(1, 3);
			end
			broken = (phase != 0) && (total > 1) && ($urandom_range(0, 7) == 0);
			count  = broken ? $urandom_range(1, total - 1) : sets * total;
			// The last phase stops at the item budget, even part of the way through a load.
			if (count > ITEM_TARGET - pairs_sent)
				count = ITEM_TARGET - pairs_sent;
			repeat (count) begin
				offer_pair(pick_word(), pick_word());
				pace();
			end
			phase++;
		end

		// Wind down: let every owed element arrive, then watch a little longer for strays.
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (ledger.errors == 0 && ledger.outstanding() == 0) begin
			$display("square_matrix_multiply_core verification clean");
		end else begin
			$display("square_matrix_multiply_core verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
rtl/core/sqmm_pkg.sv
rtl/core/sqmm_store.sv
rtl/core/sqmm_mac.sv
rtl/core/square_matrix_multiply_core.sv
sim/square_matrix_multiply_core_test.sv
